// File: rtl/core/sba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sba_pkg;

  localparam int SEG_COUNT    = 16;
  localparam int SEG_W        = 4;
  localparam int OPEN_W       = 5;
  localparam int MAX_REQUESTS = 1024;
  localparam int SLOT_W       = 10;
  localparam int CNT_W        = 11;
  localparam int BYTES_W      = 21;
  localparam int OFF_W        = 20;
  localparam int HEADER_BYTES = 8;
  localparam int ALIGN_BYTES  = 16;
  localparam logic [BYTES_W-1:0] MAX_SEGMENT_BYTES = 21'd1048576;
  localparam logic [BYTES_W-1:0] CFG_RESET         = 21'd1048576;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_ZERO_SIZE   = 3'd1,
    ST_TOO_LARGE   = 3'd2,
    ST_NO_SEGMENT  = 3'd3,
    ST_BAD_REF     = 3'd4,
    ST_DOUBLE_FREE = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_PICK,
    S_ALLOC_WR,
    S_FREE_CHK,
    S_FREE_TEST,
    S_SCAN,
    S_SCAN_CHK
  } state_e;

  typedef struct packed {
    logic    load;
    logic    size;
    logic    pick_pop;
    logic    pick_open;
    logic    alloc_wr;
    logic    clear;
    logic    free_rd;
    logic    free_mark;
    logic    scan_rd;
    logic    scan_dec;
    logic    scan_keep;
    logic    scan_empty;
    logic    finish;
    logic    fin_data;
    status_e fin_status;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  zero_size;
    logic  fits_cur;
    logic  too_large;
    logic  can_pop;
    logic  can_open;
    logic  ref_bad;
    logic  slot_freed;
    logic  is_last;
    logic  scan_zero;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/core/sba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module sba_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            start,
  output logic           busy,
  input  sba_pkg::sts_t  sts_i,
  output sba_pkg::cmd_t  cmd_o
);

  sba_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sba_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != sba_pkg::S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sba_pkg::S_IDLE: begin
        if (start) state_d = sba_pkg::S_DISPATCH;
      end
      sba_pkg::S_DISPATCH: begin
        unique case (sts_i.kind)
          sba_pkg::KIND_ALLOC: state_d = sts_i.zero_size ? sba_pkg::S_IDLE : sba_pkg::S_PICK;
          sba_pkg::KIND_FREE:  state_d = sba_pkg::S_FREE_CHK;
          default:             state_d = sba_pkg::S_IDLE;
        endcase
      end
      sba_pkg::S_PICK: begin
        priority if (sts_i.fits_cur) state_d = sba_pkg::S_ALLOC_WR;
        else if (sts_i.too_large)    state_d = sba_pkg::S_IDLE;
        else if (sts_i.can_pop || sts_i.can_open) state_d = sba_pkg::S_ALLOC_WR;
        else                         state_d = sba_pkg::S_IDLE;
      end
      sba_pkg::S_ALLOC_WR: state_d = sba_pkg::S_IDLE;
      sba_pkg::S_FREE_CHK: state_d = sts_i.ref_bad ? sba_pkg::S_IDLE : sba_pkg::S_FREE_TEST;
      sba_pkg::S_FREE_TEST: begin
        state_d = (!sts_i.slot_freed && sts_i.is_last) ? sba_pkg::S_SCAN : sba_pkg::S_IDLE;
      end
      sba_pkg::S_SCAN: state_d = sts_i.scan_zero ? sba_pkg::S_IDLE : sba_pkg::S_SCAN_CHK;
      sba_pkg::S_SCAN_CHK: state_d = sts_i.slot_freed ? sba_pkg::S_SCAN : sba_pkg::S_IDLE;
      default: state_d = sba_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    cmd_o.fin_status = sba_pkg::ST_OK;
    unique case (state_q)
      sba_pkg::S_IDLE: cmd_o.load = start;
      sba_pkg::S_DISPATCH: begin
        unique case (sts_i.kind)
          sba_pkg::KIND_ALLOC: begin
            if (sts_i.zero_size) begin
              cmd_o.finish     = 1'b1;
              cmd_o.fin_status = sba_pkg::ST_ZERO_SIZE;
            end else begin
              cmd_o.size = 1'b1;
            end
          end
          sba_pkg::KIND_FREE: ;
          sba_pkg::KIND_CLEAR: begin
            cmd_o.clear  = 1'b1;
            cmd_o.finish = 1'b1;
          end
          default: cmd_o.finish = 1'b1;
        endcase
      end
      sba_pkg::S_PICK: begin
        priority if (sts_i.fits_cur) begin
        end else if (sts_i.too_large) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = sba_pkg::ST_TOO_LARGE;
        end else if (sts_i.can_pop) begin
          cmd_o.pick_pop = 1'b1;
        end else if (sts_i.can_open) begin
          cmd_o.pick_open = 1'b1;
        end else begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = sba_pkg::ST_NO_SEGMENT;
        end
      end
      sba_pkg::S_ALLOC_WR: begin
        cmd_o.alloc_wr = 1'b1;
        cmd_o.finish   = 1'b1;
        cmd_o.fin_data = 1'b1;
      end
      sba_pkg::S_FREE_CHK: begin
        if (sts_i.ref_bad) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = sba_pkg::ST_BAD_REF;
        end else begin
          cmd_o.free_rd = 1'b1;
        end
      end
      sba_pkg::S_FREE_TEST: begin
        if (sts_i.slot_freed) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = sba_pkg::ST_DOUBLE_FREE;
        end else begin
          cmd_o.free_mark = 1'b1;
          cmd_o.finish    = !sts_i.is_last;
        end
      end
      sba_pkg::S_SCAN: begin
        if (sts_i.scan_zero) begin
          cmd_o.scan_empty = 1'b1;
          cmd_o.finish     = 1'b1;
        end else begin
          cmd_o.scan_rd = 1'b1;
        end
      end
      sba_pkg::S_SCAN_CHK: begin
        if (sts_i.slot_freed) begin
          cmd_o.scan_dec = 1'b1;
        end else begin
          cmd_o.scan_keep = 1'b1;
          cmd_o.finish    = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/sba_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module sba_datapath (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [sba_pkg::BYTES_W-1:0]  cfg_wdata_i,
  input  wire  [1:0]                   kind_i,
  input  wire  [sba_pkg::BYTES_W-1:0]  request_bytes_i,
  input  wire  [sba_pkg::SEG_W-1:0]    ref_segment_i,
  input  wire  [sba_pkg::SLOT_W-1:0]   ref_request_i,
  input  sba_pkg::cmd_t                cmd_i,
  output sba_pkg::sts_t                sts_o,
  output logic                         done_o,
  output logic [2:0]                   status_o,
  output logic [sba_pkg::SEG_W-1:0]    block_segment_o,
  output logic [sba_pkg::SLOT_W-1:0]   block_slot_o,
  output logic [sba_pkg::OFF_W-1:0]    block_offset_o,
  output logic [sba_pkg::BYTES_W-1:0]  served_bytes_o
);

  localparam int SlotAddrW = sba_pkg::SEG_W + sba_pkg::SLOT_W;
  localparam int SlotDepth = sba_pkg::SEG_COUNT * sba_pkg::MAX_REQUESTS;
  localparam logic [sba_pkg::BYTES_W:0] AlignMask = (sba_pkg::BYTES_W+1)'(sba_pkg::ALIGN_BYTES - 1);

  typedef struct packed {
    logic                        freed;
    logic [sba_pkg::BYTES_W-1:0] size;
    logic [sba_pkg::OFF_W-1:0]   off;
  } slot_t;

  logic [sba_pkg::BYTES_W-1:0] cfg_q;
  sba_pkg::kind_e              kind_q;
  logic [sba_pkg::BYTES_W-1:0] req_q;
  logic [sba_pkg::SLOT_W-1:0]  rslot_q;
  logic [sba_pkg::BYTES_W:0]   served_q;
  logic [sba_pkg::SEG_W-1:0]   seg_q;
  logic [sba_pkg::SEG_W-1:0]   cur_q;
  logic [sba_pkg::OPEN_W-1:0]  open_q;
  logic [sba_pkg::OPEN_W-1:0]  fsc_q;
  logic [sba_pkg::SEG_W-1:0]   fs_q   [sba_pkg::SEG_COUNT];
  logic [sba_pkg::BYTES_W-1:0] used_q [sba_pkg::SEG_COUNT];
  logic [sba_pkg::CNT_W-1:0]   cnt_q  [sba_pkg::SEG_COUNT];
  logic [sba_pkg::CNT_W-1:0]   scan_q;
  logic                        done_q;

  slot_t mem [SlotDepth];
  slot_t rdata_q;

  logic [sba_pkg::BYTES_W-1:0] cap;
  logic [sba_pkg::BYTES_W-1:0] used_sel;
  logic [sba_pkg::CNT_W-1:0]   cnt_sel;
  logic [sba_pkg::BYTES_W:0]   served_sum;
  logic [sba_pkg::BYTES_W:0]   fit_sum;
  logic [sba_pkg::CNT_W-1:0]   scan_m1;
  logic [sba_pkg::SEG_W-1:0]   fs_top;
  logic                        mem_we;
  logic [SlotAddrW-1:0]        mem_waddr;
  slot_t                       mem_wdata;
  logic                        mem_re;
  logic [SlotAddrW-1:0]        mem_raddr;

  assign cap        = (cfg_q > sba_pkg::MAX_SEGMENT_BYTES) ? sba_pkg::MAX_SEGMENT_BYTES : cfg_q;
  assign used_sel   = used_q[seg_q];
  assign cnt_sel    = cnt_q[seg_q];
  assign served_sum = ({1'b0, req_q} + (sba_pkg::BYTES_W+1)'(sba_pkg::HEADER_BYTES) + AlignMask)
                      & ~AlignMask;
  assign fit_sum    = {1'b0, used_sel} + served_q;
  assign scan_m1    = scan_q - sba_pkg::CNT_W'(1);
  assign fs_top     = fs_q[fsc_q[sba_pkg::SEG_W-1:0] - sba_pkg::SEG_W'(1)];

  always_comb begin
    sts_o.kind       = kind_q;
    sts_o.zero_size  = (req_q == '0);
    sts_o.fits_cur   = (fit_sum <= {1'b0, cap}) &&
                       (cnt_sel < sba_pkg::CNT_W'(sba_pkg::MAX_REQUESTS));
    sts_o.too_large  = (served_q > {1'b0, cap});
    sts_o.can_pop    = (fsc_q != '0);
    sts_o.can_open   = (open_q < sba_pkg::OPEN_W'(sba_pkg::SEG_COUNT));
    sts_o.ref_bad    = ({1'b0, seg_q} >= open_q) || ({1'b0, rslot_q} >= cnt_sel);
    sts_o.slot_freed = rdata_q.freed;
    sts_o.is_last    = ({1'b0, rslot_q} + sba_pkg::CNT_W'(1)) == cnt_sel;
    sts_o.scan_zero  = (scan_q == '0);
  end

  // slot store ports
  always_comb begin
    mem_we    = cmd_i.alloc_wr || cmd_i.free_mark;
    mem_waddr = cmd_i.alloc_wr ? {seg_q, cnt_sel[sba_pkg::SLOT_W-1:0]} : {seg_q, rslot_q};
    mem_wdata = cmd_i.alloc_wr ? slot_t'{freed: 1'b0, size: served_q[sba_pkg::BYTES_W-1:0],
                                         off: used_sel[sba_pkg::OFF_W-1:0]}
                               : slot_t'{freed: 1'b1, size: rdata_q.size, off: rdata_q.off};
    mem_re    = cmd_i.free_rd || cmd_i.scan_rd;
    mem_raddr = cmd_i.free_rd ? {seg_q, rslot_q} : {seg_q, scan_m1[sba_pkg::SLOT_W-1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  // request latch and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= sba_pkg::kind_e'(kind_i);
      req_q   <= request_bytes_i;
      rslot_q <= ref_request_i;
    end
    if (cmd_i.size) served_q <= served_sum;
    if (cmd_i.free_mark) scan_q <= {1'b0, rslot_q};
    else if (cmd_i.scan_dec) scan_q <= scan_m1;
    if (cmd_i.finish) begin
      status_o <= cmd_i.fin_status;
      if (cmd_i.fin_data) begin
        block_segment_o <= seg_q;
        block_slot_o    <= cnt_sel[sba_pkg::SLOT_W-1:0];
        block_offset_o  <= used_sel[sba_pkg::OFF_W-1:0];
        served_bytes_o  <= served_q[sba_pkg::BYTES_W-1:0];
      end else begin
        block_segment_o <= '0;
        block_slot_o    <= '0;
        block_offset_o  <= '0;
        served_bytes_o  <= '0;
      end
    end
  end

  // allocator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= sba_pkg::CFG_RESET;
      seg_q  <= '0;
      cur_q  <= '0;
      open_q <= sba_pkg::OPEN_W'(1);
      fsc_q  <= '0;
      done_q <= 1'b0;
      for (int s = 0; s < sba_pkg::SEG_COUNT; s++) begin
        used_q[s] <= '0;
        cnt_q[s]  <= '0;
      end
    end else begin
      done_q <= cmd_i.finish;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (cmd_i.load) begin
        seg_q <= (sba_pkg::kind_e'(kind_i) == sba_pkg::KIND_FREE) ? ref_segment_i : cur_q;
      end
      if (cmd_i.pick_pop) begin
        seg_q <= fs_top;
        cur_q <= fs_top;
        fsc_q <= fsc_q - sba_pkg::OPEN_W'(1);
      end
      if (cmd_i.pick_open) begin
        seg_q  <= open_q[sba_pkg::SEG_W-1:0];
        cur_q  <= open_q[sba_pkg::SEG_W-1:0];
        open_q <= open_q + sba_pkg::OPEN_W'(1);
        used_q[open_q[sba_pkg::SEG_W-1:0]] <= '0;
        cnt_q[open_q[sba_pkg::SEG_W-1:0]]  <= '0;
      end
      if (cmd_i.alloc_wr) begin
        used_q[seg_q] <= fit_sum[sba_pkg::BYTES_W-1:0];
        cnt_q[seg_q]  <= cnt_sel + sba_pkg::CNT_W'(1);
      end
      if (cmd_i.scan_keep) begin
        used_q[seg_q] <= {1'b0, rdata_q.off} + rdata_q.size;
        cnt_q[seg_q]  <= scan_q;
      end
      if (cmd_i.scan_empty) begin
        used_q[seg_q] <= '0;
        cnt_q[seg_q]  <= '0;
        // park the emptied segment unless it is the one being filled
        if (seg_q != cur_q && fsc_q < sba_pkg::OPEN_W'(sba_pkg::SEG_COUNT)) begin
          fs_q[fsc_q[sba_pkg::SEG_W-1:0]] <= seg_q;
          fsc_q <= fsc_q + sba_pkg::OPEN_W'(1);
        end
      end
      if (cmd_i.clear) begin
        cur_q <= '0;
        fsc_q <= open_q - sba_pkg::OPEN_W'(1);
        // stack entry s holds segment s+1, so the highest open segment is on top
        for (int s = 0; s < sba_pkg::SEG_COUNT; s++) begin
          used_q[s] <= '0;
          cnt_q[s]  <= '0;
          fs_q[s]   <= sba_pkg::SEG_W'(s + 1);
        end
      end
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

// File: rtl/core/segmented_bump_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Segmented bump allocator: 16 segments of up to 1024 blocks each.
// Request channel: drive kind_i (allocate, free, clear) with its operands and
// raise start; the request is taken on a clock edge where start is high and
// busy is low. busy stays high until the request is finished.
// Result channel: done_o pulses for one cycle with status_o and the block
// fields. Results cannot be held off; sample them on the done_o cycle. The
// block fields are zero unless an allocate succeeded.
// An allocate is latched, its size rounded, a segment picked and the slot
// written; a failed one ends at the pick, a zero-size one, a clear or an
// unused kind at dispatch. A bad free reference ends at its check; else the
// slot is read and tested, a double free ends there, else it is marked;
// freeing the last block walks back over trailing freed blocks via the slot
// store's single read port and registered read data, until a live block
// stays or the segment empties. A new request may be taken in the cycle its
// predecessor's done_o shows. Configuration: cfg_we_i writes segment
// capacity; the user writes it only while idle, unenforced by the block.
// Reset: segment 0 is open and current, all segments empty, capacity 1 MiB.
// Slot contents are not cleared; they are read only after being written.
module segmented_bump_allocator (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  wire                          cfg_we_i,
  input  wire  [sba_pkg::BYTES_W-1:0]  cfg_wdata_i,
  input  wire  [1:0]                   kind_i,
  input  wire  [sba_pkg::BYTES_W-1:0]  request_bytes_i,
  input  wire  [sba_pkg::SEG_W-1:0]    ref_segment_i,
  input  wire  [sba_pkg::SLOT_W-1:0]   ref_request_i,
  output logic                         done_o,
  output logic [2:0]                   status_o,
  output logic [sba_pkg::SEG_W-1:0]    block_segment_o,
  output logic [sba_pkg::SLOT_W-1:0]   block_slot_o,
  output logic [sba_pkg::OFF_W-1:0]    block_offset_o,
  output logic [sba_pkg::BYTES_W-1:0]  served_bytes_o
);

  sba_pkg::cmd_t cmd;
  sba_pkg::sts_t sts;

  // sequencer: walks each request through its steps
  sba_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // segment tables, free stack, slot store and result registers
  sba_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .kind_i          (kind_i),
    .request_bytes_i (request_bytes_i),
    .ref_segment_i   (ref_segment_i),
    .ref_request_i   (ref_request_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .done_o          (done_o),
    .status_o        (status_o),
    .block_segment_o (block_segment_o),
    .block_slot_o    (block_slot_o),
    .block_offset_o  (block_offset_o),
    .served_bytes_o  (served_bytes_o)
  );

endmodule
`default_nettype wire

// File: rtl/core/sba_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module sba_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          start,
  input wire                          busy,
  input wire                          done_o,
  input wire [2:0]                    status_o,
  input wire [sba_pkg::SEG_W-1:0]     block_segment_o,
  input wire [sba_pkg::SLOT_W-1:0]    block_slot_o,
  input wire [sba_pkg::OFF_W-1:0]     block_offset_o,
  input wire [sba_pkg::BYTES_W-1:0]   served_bytes_o
);

  // a result shows only once its request has retired
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");

  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("request not taken");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result repeated");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != sba_pkg::ST_OK) |->
      (block_segment_o == '0) && (block_slot_o == '0) &&
      (block_offset_o == '0) && (served_bytes_o == '0))
    else $error("error result carries block data");

  a_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == sba_pkg::ST_OK) |->
      (served_bytes_o[3:0] == 4'd0) && (block_offset_o[3:0] == 4'd0))
    else $error("block not aligned");

endmodule

bind segmented_bump_allocator sba_checker u_sba_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .status_o        (status_o),
  .block_segment_o (block_segment_o),
  .block_slot_o    (block_slot_o),
  .block_offset_o  (block_offset_o),
  .served_bytes_o  (served_bytes_o)
);
`default_nettype wire
